@@ hdl/socest_pkg.sv @@
// Shared types and constants for the LiPo state-of-charge estimator.
package socest_pkg;

  localparam int VOLT_W   = 13;
  localparam int LOAD_W   = 16;
  localparam int CAP_W    = 16;
  localparam int SOC_W    = 7;

  // Compensation divide: voltage * capacity * 100 over capacity * 100 - load.
  localparam int DVSR_W   = 23;
  localparam int NUM_W    = 36;
  // Cell count and per-cell thresholds.
  localparam int N_W      = 5;
  localparam int VN_W     = 14;
  // Interpolation divide dividend width.
  localparam int SDIV_W   = 17;
  localparam int CNT_W    = 6;

  localparam int LOAD_SCALE      = 100;
  localparam int CELL_NOMINAL_CV = 370;
  localparam int CELL_FULL_CV    = 424;
  localparam int CELL_EMPTY_CV   = 296;
  localparam int CELL_HALF_CV    = CELL_NOMINAL_CV / 2;
  localparam int UPPER_SPAN_CV   = CELL_FULL_CV - CELL_NOMINAL_CV;
  localparam int LOWER_SPAN_CV   = CELL_NOMINAL_CV - CELL_EMPTY_CV;
  localparam int SOC_UPPER_SPAN  = 80;
  localparam int SOC_KNEE        = 20;
  localparam int SOC_FULL        = 100;

  // floor(x / 370) as (x * 2834) >> 20, exact for x below 2**14.
  localparam int CELL_RECIP       = 2834;
  localparam int CELL_RECIP_W     = 12;
  localparam int CELL_RECIP_SHIFT = 20;

  typedef struct packed {
    logic              bad;
    logic [NUM_W-1:0]  num;
    logic [DVSR_W-1:0] dvsr;
    logic [N_W-1:0]    n;
  } socest_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_V,
    ST_SEG,
    ST_DIV_S,
    ST_FIN
  } socest_state_e;

endpackage

@@ hdl/socest_front.sv @@
// Front end: capacity register, load check, dividend, divisor and cell count.
module socest_front
  import socest_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CAP_W-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [VOLT_W-1:0]  voltage_cv_i,
  input  logic [LOAD_W-1:0]  load_ma_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output socest_item_t       q_item_o
);

  localparam int X_W    = VN_W;
  localparam int PROD_W = X_W + CELL_RECIP_W;

  logic [DVSR_W-1:0] denom_q, denom_d;
  logic [X_W-1:0]    cell_x;
  logic [PROD_W-1:0] cell_prod;

  // Keep capacity pre-scaled by 100.
  always_comb begin
    denom_d = denom_q;
    if (cfg_we_i) begin
      denom_d = DVSR_W'(cfg_wdata_i * DVSR_W'(LOAD_SCALE));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      denom_q <= '0;
    end else begin
      denom_q <= denom_d;
    end
  end

  // Round to nearest cell count: floor((v + 185) / 370).
  assign cell_x    = X_W'(voltage_cv_i) + X_W'(CELL_HALF_CV);
  assign cell_prod = PROD_W'(cell_x) * PROD_W'(CELL_RECIP);

  assign in_stall_o     = q_full_i;
  assign q_push_o       = in_valid_i && !q_full_i;
  assign q_item_o.bad   = denom_q <= DVSR_W'(load_ma_i);
  assign q_item_o.num   = NUM_W'(voltage_cv_i) * NUM_W'(denom_q);
  assign q_item_o.dvsr  = denom_q - DVSR_W'(load_ma_i);
  assign q_item_o.n     = cell_prod[CELL_RECIP_SHIFT +: N_W];

endmodule

@@ hdl/socest_fifo.sv @@
// Short queue of classified items between front and back end.
module socest_fifo
  import socest_pkg::*;
#(
  parameter int DEPTH = 2
)(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  socest_item_t wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output socest_item_t rdata_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  socest_item_t    mem_q [DEPTH];
  logic [AW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + AW'(1);
    end
    return r;
  endfunction

  assign full_o  = cnt_q == CW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? ptr_next(wptr_q) : wptr_q;
    rptr_d = pop_i  ? ptr_next(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

@@ hdl/socest_back.sv @@
// Back end: bit-serial divider, interpolation sequencer and output register.
module socest_back
  import socest_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  socest_item_t     q_item_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [SOC_W-1:0] soc_percent_o,
  output logic             bad_load_o
);

  socest_state_e     state_q, state_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [DVSR_W-1:0] rem_q, rem_d;
  logic [DVSR_W-1:0] dvsr_q, dvsr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [N_W-1:0]    n_q, n_d;
  logic [SOC_W-1:0]  base_q, base_d;
  logic [SOC_W-1:0]  res_soc_q, res_soc_d;
  logic              res_bad_q, res_bad_d;
  logic              out_valid_q, out_valid_d;
  logic [SOC_W-1:0]  out_soc_q, out_soc_d;
  logic              out_bad_q, out_bad_d;

  logic [DVSR_W:0]   rem_sh;
  logic              fits;
  logic [DVSR_W-1:0] step_rem;
  logic [NUM_W-1:0]  step_quo;
  logic [VN_W-1:0]   vn, top, bottom;
  logic [VN_W-1:0]   diff_hi, diff_lo;

  // One restoring divide step per cycle.
  assign rem_sh   = {rem_q, quo_q[NUM_W-1]};
  assign fits     = rem_sh >= {1'b0, dvsr_q};
  assign step_rem = fits ? DVSR_W'(rem_sh - {1'b0, dvsr_q}) : rem_sh[DVSR_W-1:0];
  assign step_quo = {quo_q[NUM_W-2:0], fits};

  assign vn      = VN_W'(n_q * VN_W'(CELL_NOMINAL_CV));
  assign top     = VN_W'(n_q * VN_W'(CELL_FULL_CV));
  assign bottom  = VN_W'(n_q * VN_W'(CELL_EMPTY_CV));
  assign diff_hi = quo_q[VN_W-1:0] - vn;
  assign diff_lo = quo_q[VN_W-1:0] - bottom;

  always_comb begin
    state_d     = state_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    dvsr_d      = dvsr_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    base_d      = base_q;
    res_soc_d   = res_soc_q;
    res_bad_d   = res_bad_q;
    out_soc_d   = out_soc_q;
    out_bad_d   = out_bad_q;
    out_valid_d = out_valid_q && out_stall_i;
    q_pop_o     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          n_d     = q_item_i.n;
          quo_d   = q_item_i.num;
          rem_d   = '0;
          dvsr_d  = q_item_i.dvsr;
          cnt_d   = CNT_W'(NUM_W - 1);
          if (q_item_i.bad) begin
            res_soc_d = '0;
            res_bad_d = 1'b1;
            state_d   = ST_FIN;
          end else begin
            res_bad_d = 1'b0;
            state_d   = ST_DIV_V;
          end
        end
      end
      ST_DIV_V, ST_DIV_S: begin
        quo_d = step_quo;
        rem_d = step_rem;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          if (state_q == ST_DIV_V) begin
            state_d = ST_SEG;
          end else begin
            res_soc_d = base_q + step_quo[SOC_W-1:0];
            state_d   = ST_FIN;
          end
        end
      end
      ST_SEG: begin
        // Pick the segment from the compensated voltage; clamp at both ends.
        rem_d = '0;
        cnt_d = CNT_W'(SDIV_W - 1);
        if (quo_q >= NUM_W'(vn)) begin
          if (quo_q >= NUM_W'(top)) begin
            res_soc_d = SOC_W'(SOC_FULL);
            state_d   = ST_FIN;
          end else begin
            quo_d   = {SDIV_W'(diff_hi * SDIV_W'(SOC_UPPER_SPAN)), (NUM_W - SDIV_W)'(0)};
            dvsr_d  = DVSR_W'(n_q * DVSR_W'(UPPER_SPAN_CV));
            base_d  = SOC_W'(SOC_KNEE);
            state_d = ST_DIV_S;
          end
        end else begin
          if (quo_q <= NUM_W'(bottom)) begin
            res_soc_d = '0;
            state_d   = ST_FIN;
          end else begin
            quo_d   = {SDIV_W'(diff_lo * SDIV_W'(SOC_KNEE)), (NUM_W - SDIV_W)'(0)};
            dvsr_d  = DVSR_W'(n_q * DVSR_W'(LOWER_SPAN_CV));
            base_d  = '0;
            state_d = ST_DIV_S;
          end
        end
      end
      ST_FIN: begin
        // Hold the result until the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_soc_d   = res_soc_q;
          out_bad_d   = res_bad_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    dvsr_q    <= dvsr_d;
    cnt_q     <= cnt_d;
    n_q       <= n_d;
    base_q    <= base_d;
    res_soc_q <= res_soc_d;
    res_bad_q <= res_bad_d;
    out_soc_q <= out_soc_d;
    out_bad_q <= out_bad_d;
  end

  assign out_valid_o   = out_valid_q;
  assign soc_percent_o = out_soc_q;
  assign bad_load_o    = out_bad_q;

endmodule

@@ hdl/lipo_state_of_charge_estimator_top.sv @@
// Top level of the LiPo state-of-charge estimator.
//
// Input channel: voltage_cv_i (1/100 V) and load_ma_i (mA) transfer when
// in_valid_i is high and in_stall_o is low. Output channel: soc_percent_o
// and bad_load_o transfer when out_valid_o is high and out_stall_i is low.
// Capacity in mAh is written through cfg_we_i / cfg_wdata_i while idle.
//
// The front end checks the load, forms the compensation dividend, divisor
// and cell count in the transfer cycle and pushes them into a queue of
// QUEUE_DEPTH entries. The back end runs a one-bit-per-cycle divider:
// 36 steps for the compensated voltage, then 17 steps for interpolation.
// An item occupies the back end until it returns to ST_IDLE; a clamped
// item skips the interpolation divide and a bad load skips both divides.
// The front keeps taking items, until the queue is full, while the back end
// works or the output waits; a stalled result holds in the output register
// and the back end holds its next result until that register frees up.
// Reset clears the capacity to zero, empties the queue and drops any
// pending result.
module lipo_state_of_charge_estimator_top
  import socest_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
)(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CAP_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [VOLT_W-1:0] voltage_cv_i,
  input  logic [LOAD_W-1:0] load_ma_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SOC_W-1:0]  soc_percent_o,
  output logic              bad_load_o
);

  logic         q_full, q_push, q_pop, q_empty;
  socest_item_t q_wdata, q_rdata;

  socest_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .voltage_cv_i (voltage_cv_i),
    .load_ma_i    (load_ma_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_item_o     (q_wdata)
  );

  socest_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_rdata)
  );

  socest_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_item_i      (q_rdata),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .soc_percent_o (soc_percent_o),
    .bad_load_o    (bad_load_o)
  );

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the LiPo state-of-charge estimator top level.
`timescale 1ns / 100ps

module tb
  import socest_pkg::*;
();

  typedef struct packed {
    logic [SOC_W-1:0] soc;
    logic             bad;
  } soc_result_t;

  typedef struct packed {
    logic [CAP_W-1:0]  cap;
    logic [VOLT_W-1:0] volt;
    logic [LOAD_W-1:0] load;
    logic              typed;
    logic [SOC_W-1:0]  soc;
    logic              bad;
  } stim_row_t;

  localparam int N_DIRECTED   = 24;
  localparam int N_PHASES     = 13;
  localparam int PHASE_ITEMS  = 150;
  localparam int SETTLE_CYC   = 64;

  // Directed rows: capacity, voltage, load, typed flag, soc, bad load.
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{16'd0,     13'd0,    16'd0,     1'b1, 7'd0,   1'b1},
    '{16'd0,     13'd8191, 16'd65535, 1'b1, 7'd0,   1'b1},
    '{16'd0,     13'd5000, 16'd0,     1'b1, 7'd0,   1'b1},
    '{16'd65535, 13'd0,    16'd0,     1'b1, 7'd100, 1'b0},
    '{16'd65535, 13'd184,  16'd0,     1'b1, 7'd100, 1'b0},
    '{16'd65535, 13'd185,  16'd0,     1'b1, 7'd0,   1'b0},
    '{16'd65535, 13'd370,  16'd0,     1'b1, 7'd20,  1'b0},
    '{16'd65535, 13'd424,  16'd0,     1'b1, 7'd100, 1'b0},
    '{16'd65535, 13'd296,  16'd0,     1'b1, 7'd0,   1'b0},
    '{16'd65535, 13'd8191, 16'd0,     1'b0, 7'd0,   1'b0},
    '{16'd65535, 13'd8191, 16'd65535, 1'b0, 7'd0,   1'b0},
    '{16'd65535, 13'd5000, 16'd65535, 1'b0, 7'd0,   1'b0},
    '{16'd1,     13'd370,  16'd99,    1'b0, 7'd0,   1'b0},
    '{16'd1,     13'd370,  16'd100,   1'b1, 7'd0,   1'b1},
    '{16'd1,     13'd8191, 16'd65535, 1'b1, 7'd0,   1'b1},
    '{16'd656,   13'd4000, 16'd65535, 1'b0, 7'd0,   1'b0},
    '{16'd656,   13'd1,    16'd65535, 1'b0, 7'd0,   1'b0},
    '{16'd1000,  13'd740,  16'd0,     1'b1, 7'd20,  1'b0},
    '{16'd1000,  13'd592,  16'd0,     1'b1, 7'd0,   1'b0},
    '{16'd1000,  13'd848,  16'd0,     1'b1, 7'd100, 1'b0},
    '{16'd1000,  13'd1500, 16'd2500,  1'b0, 7'd0,   1'b0},
    '{16'd1000,  13'd1110, 16'd30000, 1'b0, 7'd0,   1'b0},
    '{16'd32768, 13'd4096, 16'd32768, 1'b0, 7'd0,   1'b0},
    '{16'd1000,  13'd333,  16'd0,     1'b0, 7'd0,   1'b0}
  };

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              cfg_we       = 1'b0;
  logic [CAP_W-1:0]  cfg_wdata    = '0;
  logic              in_valid     = 1'b0;
  logic              in_stall_o;
  logic [VOLT_W-1:0] voltage_cv   = '0;
  logic [LOAD_W-1:0] load_ma      = '0;
  logic              out_valid_o;
  logic              out_stall    = 1'b0;
  logic [SOC_W-1:0]  soc_percent_o;
  logic              bad_load_o;

  soc_result_t       soc_expected [$];
  soc_result_t       head_result;
  logic [CAP_W-1:0]  cap_shadow   = '0;
  int                errors       = 0;
  int                stall_left   = 0;
  bit                quiet_run    = 1'b0;

  int                cap_pick;
  int                cells;
  int                per_cell;
  int                volt_pick;
  int                load_cap;

  lipo_state_of_charge_estimator_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .voltage_cv_i  (voltage_cv),
    .load_ma_i     (load_ma),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .soc_percent_o (soc_percent_o),
    .bad_load_o    (bad_load_o)
  );

  always #10 clk_i = ~clk_i;

  // Load-compensated voltage, cell count and piecewise-linear interpolation.
  function automatic soc_result_t soc_estimate(logic [CAP_W-1:0] cap,
                                               logic [VOLT_W-1:0] volt,
                                               logic [LOAD_W-1:0] load);
    longint unsigned denom, v, n, vn, top, bottom, pct;
    soc_result_t r;
    r.soc = '0;
    r.bad = 1'b0;
    denom = 64'(cap) * 64'(LOAD_SCALE);
    if (denom <= 64'(load)) begin
      r.bad = 1'b1;
      return r;
    end
    v  = (64'(volt) * 64'(LOAD_SCALE) * 64'(cap)) / (denom - 64'(load));
    n  = (64'd2 * 64'(volt)) / 64'(CELL_NOMINAL_CV);
    n  = (n >> 1) + (n & 64'd1);
    vn = n * 64'(CELL_NOMINAL_CV);
    if (v >= vn) begin
      top = n * 64'(CELL_FULL_CV);
      if (v >= top) begin
        pct = 64'(SOC_FULL);
      end else begin
        pct = 64'(SOC_KNEE) + ((v - vn) * 64'(SOC_UPPER_SPAN)) / (top - vn);
      end
    end else begin
      bottom = n * 64'(CELL_EMPTY_CV);
      if (v <= bottom) begin
        pct = 64'd0;
      end else begin
        pct = ((v - bottom) * 64'(SOC_KNEE)) / (vn - bottom);
      end
    end
    r.soc = pct[SOC_W-1:0];
    return r;
  endfunction

  // Drive one sample, hold it until the transfer, then queue its estimate.
  task automatic send_sample(logic [VOLT_W-1:0] volt, logic [LOAD_W-1:0] load,
                             logic typed, logic [SOC_W-1:0] tsoc, logic tbad);
    int gap;
    if (!quiet_run && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid   <= 1'b1;
    voltage_cv <= volt;
    load_ma    <= load;
    do @(posedge clk_i); while (in_stall_o);
    if (typed) begin
      soc_expected.push_back('{soc: tsoc, bad: tbad});
    end else begin
      soc_expected.push_back(soc_estimate(cap_shadow, volt, load));
    end
  endtask

  // Drain, let the back end settle, then write the capacity register.
  task automatic set_capacity(logic [CAP_W-1:0] value);
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (soc_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we     <= 1'b1;
    cfg_wdata  <= value;
    cap_shadow = value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Receiver stalls in bursts of random length.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (soc_expected.size() == 0) begin
        $error("unexpected result: soc_percent %0d bad_load %0d",
               soc_percent_o, bad_load_o);
        errors++;
      end else begin
        head_result = soc_expected.pop_front();
        if (soc_percent_o !== head_result.soc) begin
          $error("soc_percent: expected %0d, got %0d", head_result.soc, soc_percent_o);
          errors++;
        end
        if (bad_load_o !== head_result.bad) begin
          $error("bad_load: expected %0d, got %0d", head_result.bad, bad_load_o);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED_ROWS[i].cap != cap_shadow) set_capacity(DIRECTED_ROWS[i].cap);
      send_sample(DIRECTED_ROWS[i].volt, DIRECTED_ROWS[i].load, DIRECTED_ROWS[i].typed,
                  DIRECTED_ROWS[i].soc, DIRECTED_ROWS[i].bad);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       cap_pick = 65535;
        1:       cap_pick = 0;
        2:       cap_pick = 1;
        3:       cap_pick = 656;
        default: cap_pick = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535)
                                                         : $urandom_range(300, 5000);
      endcase
      set_capacity(cap_pick[CAP_W-1:0]);
      // No idling on either side in the last phase.
      if (ph == N_PHASES - 1) quiet_run = 1'b1;
      load_cap = cap_pick * LOAD_SCALE / 8;
      if (load_cap > 65535) load_cap = 65535;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (cap_pick != 0 && $urandom_range(0, 3) != 0) begin
          // Realistic pack: 1 to 22 cells, each between 280 and 440 cV, a little past empty and full.
          cells     = $urandom_range(1, 22);
          per_cell  = $urandom_range(280, 440);
          volt_pick = cells * per_cell;
          if (volt_pick > 8191) volt_pick = 8191;
          send_sample(volt_pick[VOLT_W-1:0], 16'($urandom_range(0, load_cap)),
                      1'b0, '0, 1'b0);
        end else begin
          send_sample(13'($urandom_range(0, 8191)), 16'($urandom_range(0, 65535)),
                      1'b0, '0, 1'b0);
        end
      end
    end

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (soc_expected.size() != 0) @(posedge clk_i);
    repeat (2 * SETTLE_CYC) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/socest_pkg.sv
hdl/socest_front.sv
hdl/socest_fifo.sv
hdl/socest_back.sv
hdl/lipo_state_of_charge_estimator_top.sv
verif/tb.sv
